@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh - shared concurrent assertion macros
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define RLE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be seen at a clock edge out of reset.
`define RLE_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ sv/rle_pkg.sv @@
// ----------------------------------------------------------------------------
// rle_pkg - shared types for the run-length decoder
// Phase encoding, decoder state and result item layout.
// ----------------------------------------------------------------------------
package rle_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned LEFT_W  = 7;
    localparam int unsigned COUNT_W = 8;

    typedef enum logic [2:0] {
        PH_CTRL = 3'b001,
        PH_FILL = 3'b010,
        PH_LIT  = 3'b100
    } phase_t;

    typedef struct packed {
        phase_t              phase;
        logic [LEFT_W-1:0]   literal_left;
        logic [COUNT_W-1:0]  fill_length;
    } dec_state_t;

    typedef struct packed {
        logic [BYTE_W-1:0]   out_value;
        logic [COUNT_W-1:0]  repeat_count;
        logic                end_of_stream;
    } run_item_t;

endpackage

@@ sv/rle_byte_if.sv @@
// ----------------------------------------------------------------------------
// rle_byte_if - compressed byte channel
// valid/ready handshake carrying one stream byte per item.
// ----------------------------------------------------------------------------
interface rle_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

@@ sv/rle_run_if.sv @@
// ----------------------------------------------------------------------------
// rle_run_if - decoded run channel
// valid/ready handshake carrying one (value, count, end) item.
// ----------------------------------------------------------------------------
interface rle_run_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_value;
    logic [7:0] repeat_count;
    logic       end_of_stream;

    modport source (output valid, output out_value, output repeat_count,
                    output end_of_stream, input ready);
    modport sink   (input valid, input out_value, input repeat_count,
                    input end_of_stream, output ready);
endinterface

@@ sv/rle_step.sv @@
// ----------------------------------------------------------------------------
// rle_step - per-byte decode logic
// Next state and optional run item for one compressed byte.
// ----------------------------------------------------------------------------
module rle_step
    import rle_pkg::*;
(
    input  dec_state_t          state,
    input  logic [BYTE_W-1:0]   in_byte,
    output dec_state_t          state_next,
    output logic                has_item,
    output run_item_t           item
);

    logic is_ctrl;

    // Byte is a control byte unless a fill value or a literal is pending.
    assign is_ctrl = !((state.phase == PH_FILL) ||
                       ((state.phase == PH_LIT) && (state.literal_left != '0)));

    always_comb
    begin
        state_next         = state;
        has_item           = 1'b0;
        item.out_value     = in_byte;
        item.repeat_count  = COUNT_W'(1);
        item.end_of_stream = 1'b0;

        if (is_ctrl)
        begin
            state_next.phase = PH_CTRL;
            if (in_byte == '0)
            begin
                has_item           = 1'b1;
                item.out_value     = '0;
                item.repeat_count  = '0;
                item.end_of_stream = 1'b1;
            end
            else if (in_byte[BYTE_W-1])
            begin
                // -c + 1 for a negative control byte, modulo 256
                state_next.fill_length = COUNT_W'(1) - in_byte;
                state_next.phase       = PH_FILL;
            end
            else
            begin
                state_next.literal_left = in_byte[LEFT_W-1:0];
                state_next.phase        = PH_LIT;
            end
        end
        else
        begin
            has_item = 1'b1;
            case (state.phase)
                PH_FILL:
                begin
                    item.repeat_count = state.fill_length;
                    state_next.phase  = PH_CTRL;
                end
                default:
                begin
                    state_next.literal_left = state.literal_left - LEFT_W'(1);
                    if (state.literal_left == LEFT_W'(1))
                    begin
                        state_next.phase = PH_CTRL;
                    end
                end
            endcase
        end
    end

endmodule

@@ sv/rle_run_decoder.sv @@
// Flow: a byte accepted into the input register is decoded there; its run
//   item loads the output register once the output slot is free.
// Throughput: one byte per cycle while the output slot is free; a control
//   byte that only loads state frees its slot without needing the output register.
// Reset: rst_n async active low clears both valid flags and returns the
//   decoder to expecting a control byte with zero counters.
// ----------------------------------------------------------------------------
// rle_run_decoder - PackBits-style run-length decoder
// Input register -> decode step -> output register; one run item per data byte or end marker.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rle_run_decoder
    import rle_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    rle_byte_if.sink        comp,
    rle_run_if.source       runs
);

    // Input register
    logic               in_valid_reg;
    logic [BYTE_W-1:0]  in_byte_reg;

    // Decoder state
    dec_state_t         state_reg;
    dec_state_t         state_next;

    // Output register
    logic               out_valid_reg;
    run_item_t          out_item_reg;

    logic               has_item;
    run_item_t          item;
    logic               out_free;
    logic               stage_fire;
    logic               in_fire;

    rle_step u_step
    (
        .state      (state_reg),
        .in_byte    (in_byte_reg),
        .state_next (state_next),
        .has_item   (has_item),
        .item       (item)
    );

    // Output slot frees when empty or being drained this cycle.
    assign out_free   = !out_valid_reg || runs.ready;
    // A byte leaves the input register if it makes no item or the slot is free.
    assign stage_fire = in_valid_reg && (!has_item || out_free);
    assign comp.ready = !in_valid_reg || stage_fire;
    assign in_fire    = comp.valid && comp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (comp.ready)
        begin
            in_valid_reg <= comp.valid;
        end
    end

    // Payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_byte_reg <= comp.in_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase        <= PH_CTRL;
            state_reg.literal_left <= '0;
            state_reg.fill_length  <= '0;
        end
        else if (stage_fire)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (stage_fire && has_item)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (runs.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_fire && has_item)
        begin
            out_item_reg <= item;
        end
    end

    assign runs.valid         = out_valid_reg;
    assign runs.out_value     = out_item_reg.out_value;
    assign runs.repeat_count  = out_item_reg.repeat_count;
    assign runs.end_of_stream = out_item_reg.end_of_stream;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // Literal phase always has at least one literal pending.
    `RLE_ASSERT_NEVER(a_lit_nonzero, (state_reg.phase == PH_LIT) && (state_reg.literal_left == '0), "literal phase with zero left")

    // End marker carries zero value and zero count.
    `RLE_ASSERT(a_eos_zero, (out_valid_reg && out_item_reg.end_of_stream) |-> ((out_item_reg.out_value == '0) && (out_item_reg.repeat_count == '0)), "end marker payload not zero")

    // Data items have a count of one (literal) or 2..129 (fill).
    `RLE_ASSERT(a_count_range, (out_valid_reg && !out_item_reg.end_of_stream) |-> ((out_item_reg.repeat_count >= COUNT_W'(1)) && (out_item_reg.repeat_count <= COUNT_W'(129))), "run count out of range")

    // An item produced by the decode step reaches the output register.
    `RLE_ASSERT(a_item_loaded, (stage_fire && has_item) |=> out_valid_reg, "decoded item dropped")

endmodule

@@ sim/tb_rle_run_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rle_run_decoder - self-checking bench for the run-length decoder
// Drives compressed bytes under random idle and stall patterns, decodes each
// accepted byte with a local model of the decoder and checks every run item
// in order against the model's output.
// ----------------------------------------------------------------------------
module tb_rle_run_decoder;
    import rle_pkg::*;

    localparam int CLK_PERIOD  = 10;
    localparam int RST_CYCLES  = 7;
    // Pause that lets the pipeline settle after every expected item is back.
    localparam int SETTLE      = 6;
    // Watchdog limit, kept above the receiver hold-off of HOLD_CYCLES.
    localparam int STALL_LIMIT = 1000;
    localparam int HOLD_CYCLES = 80;

    // Control byte values with special meaning
    localparam logic [BYTE_W-1:0] END_MARK  = 8'h00;
    localparam logic [BYTE_W-1:0] LIT_MAX   = 8'h7F;  // 127 literals follow
    localparam logic [BYTE_W-1:0] FILL_MAX  = 8'h80;  // repeat 129 times
    localparam logic [BYTE_W-1:0] FILL_MIN  = 8'hFF;  // repeat 2 times

    logic clk = 1'b0;
    logic rst_n;

    rle_byte_if comp_if ();
    rle_run_if  runs_if ();

    rle_run_decoder DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .comp  (comp_if),
        .runs  (runs_if)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------
    // Decoder model state and expected run items
    // ------------------------------------------------------------------
    phase_t              dec_phase;
    logic [LEFT_W-1:0]   lit_left;
    logic [COUNT_W-1:0]  fill_len;
    run_item_t           pending_runs[$];

    // Knobs shared between the stimulus tasks and the channel drivers
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left     = 0;

    // Statistics and error tracking
    int mismatches  = 0;
    int idle_cycles = 0;
    int n_bytes     = 0;
    int n_literals  = 0;
    int n_fills     = 0;
    int n_ends      = 0;

    // Decode one byte; returns 1 when the byte yields a run item.
    // A nonzero control byte only loads the counters.
    function automatic bit decode_byte(input logic [BYTE_W-1:0] b, output run_item_t run);
        bit produced;
        produced = 1'b1;
        run      = '0;
        if (dec_phase == PH_FILL) begin
            run.out_value    = b;
            run.repeat_count = fill_len;
            dec_phase        = PH_CTRL;
        end
        else if (dec_phase == PH_LIT && lit_left != '0) begin
            run.out_value    = b;
            run.repeat_count = COUNT_W'(1);
            lit_left         = lit_left - LEFT_W'(1);
            if (lit_left == '0)
                dec_phase = PH_CTRL;
        end
        else begin
            // Control byte; anything else falls back here as well
            dec_phase = PH_CTRL;
            if (b == END_MARK) begin
                run.end_of_stream = 1'b1;
            end
            else if (b[BYTE_W-1]) begin
                // negative c repeats -c+1 times, i.e. 257 - b
                fill_len  = COUNT_W'(9'd257 - {1'b0, b});
                dec_phase = PH_FILL;
                produced  = 1'b0;
            end
            else begin
                lit_left  = b[LEFT_W-1:0];
                dec_phase = PH_LIT;
                produced  = 1'b0;
            end
        end
        return produced;
    endfunction

    // ------------------------------------------------------------------
    // Monitor: check the output first, then decode the accepted input.
    // Doing both in one block keeps queue order independent of scheduling.
    // ------------------------------------------------------------------
    always @(posedge clk) begin : monitor
        run_item_t want;
        run_item_t got;
        bit        produced;
        if (rst_n) begin
            if (runs_if.valid && runs_if.ready) begin
                got.out_value     = runs_if.out_value;
                got.repeat_count  = runs_if.repeat_count;
                got.end_of_stream = runs_if.end_of_stream;
                if (pending_runs.size() == 0) begin
                    $error("unexpected run item: value %0d count %0d end %0b",
                           got.out_value, got.repeat_count, got.end_of_stream);
                    mismatches++;
                end
                else begin
                    want = pending_runs.pop_front();
                    if (got.out_value !== want.out_value) begin
                        $error("out_value: expected %0d, got %0d",
                               want.out_value, got.out_value);
                        mismatches++;
                    end
                    if (got.repeat_count !== want.repeat_count) begin
                        $error("repeat_count: expected %0d, got %0d",
                               want.repeat_count, got.repeat_count);
                        mismatches++;
                    end
                    if (got.end_of_stream !== want.end_of_stream) begin
                        $error("end_of_stream: expected %0b, got %0b",
                               want.end_of_stream, got.end_of_stream);
                        mismatches++;
                    end
                    if (want.end_of_stream)
                        n_ends++;
                    else if (want.repeat_count == COUNT_W'(1))
                        n_literals++;
                    else
                        n_fills++;
                end
            end
            if (comp_if.valid && comp_if.ready) begin
                if (decode_byte(comp_if.in_byte, want))
                    pending_runs.push_back(want);
            end
            if ((comp_if.valid && comp_if.ready) || (runs_if.valid && runs_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
    end

    // Watchdog: a stretch with no traffic on either channel means a hang
    initial begin : watchdog
        wait (idle_cycles >= STALL_LIMIT);
        $display("Timeout: no item moved for %0d cycles", STALL_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: random stalls, plus a counted hold-off when requested
    // ------------------------------------------------------------------
    initial begin : receiver
        runs_if.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_left > 0) begin
                runs_if.ready <= 1'b0;
                hold_left--;
            end
            else begin
                runs_if.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender side. Tasks are entered and left at a falling edge; valid
    // stays high between back-to-back items.
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            comp_if.valid <= 1'b0;
            @(negedge clk);
        end
        comp_if.valid   <= 1'b1;
        comp_if.in_byte <= b;
        @(posedge clk);
        while (!comp_if.ready)
            @(posedge clk);
        n_bytes++;
        @(negedge clk);
    endtask

    // Pause the sender until every expected run item has come back
    task automatic wait_for_runs();
        comp_if.valid <= 1'b0;
        while (pending_runs.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    // Extremes of the fill class, a single literal, back-to-back end markers,
    // zero and 0xFF as data, and restart after an end marker.
    task automatic test_directed_cases();
        logic [BYTE_W-1:0] seq[$];
        seq = '{END_MARK,                   // end marker straight after reset
                FILL_MIN, 8'h00,            // shortest run, zero value
                8'h81, 8'hAA,               // run of 128
                FILL_MAX, 8'hFF,            // longest run, all-ones value
                8'h01, 8'h55,               // single literal
                8'h02, 8'h00, 8'hFF,        // literal data that looks like control
                END_MARK, END_MARK,         // consecutive end markers
                8'hFE, 8'h80,               // run of 3, value with top bit only
                8'h03, 8'h01, 8'h7F, 8'h80, // literals around the sign boundary
                END_MARK};
        send_idle_pct = 0;
        recv_idle_pct = 0;
        foreach (seq[i])
            send_byte(seq[i]);
        wait_for_runs();
    endtask

    // Longest literal block while the receiver holds off: the pipeline
    // fills and the decoder must stall its input without losing bytes.
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_left     = HOLD_CYCLES;
        send_byte(LIT_MAX);
        repeat (int'(LIT_MAX))
            send_byte(8'($urandom_range(255)));
        send_byte(END_MARK);
        wait_for_runs();
    endtask

    // Mostly well-formed packets with random content, some stray bytes
    // that break framing. Stops at a packet boundary once the target is met.
    task automatic test_random_streams(input int target, input int send_pct,
                                       input int recv_pct);
        int sent;
        int kind;
        int len;
        sent          = 0;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        while (sent < target) begin
            kind = $urandom_range(99);
            if (kind < 45) begin
                // literal packet, now and then a long one
                len = ($urandom_range(19) == 0) ? $urandom_range(127, 1)
                                                : $urandom_range(8, 1);
                send_byte(8'(len));
                repeat (len)
                    send_byte(8'($urandom_range(255)));
                sent += len + 1;
            end
            else if (kind < 85) begin
                // fill packet, any repeat count
                send_byte(8'($urandom_range(255, 128)));
                send_byte(8'($urandom_range(255)));
                sent += 2;
            end
            else if (kind < 95) begin
                send_byte(END_MARK);
                sent++;
            end
            else begin
                // stray byte; may land anywhere in the framing
                send_byte(8'($urandom_range(255)));
                sent++;
            end
        end
        wait_for_runs();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : main
        rst_n           = 1'b0;
        comp_if.valid   = 1'b0;
        comp_if.in_byte = '0;
        dec_phase       = PH_CTRL;
        lit_left        = '0;
        fill_len        = '0;
        repeat (RST_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed_cases();
        test_backpressure();
        test_random_streams(100, 0, 0);     // no idling
        test_random_streams(100, 75, 0);    // sparse sender
        test_random_streams(100, 0, 75);    // slow receiver
        test_random_streams(100, 12, 12);   // light idling on both sides

        $display("Sent %0d stream bytes; checked %0d literals, %0d fill runs, %0d end markers.",
                 n_bytes, n_literals, n_fills, n_ends);
        $display("Covered every control class, a long receiver hold-off and four idle mixes.");
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

@@ rle_run_decoder.f @@
+incdir+sv
sv/rle_pkg.sv
sv/rle_byte_if.sv
sv/rle_run_if.sv
sv/rle_step.sv
sv/rle_run_decoder.sv
sim/tb_rle_run_decoder.sv
